// ===== hdl/mao_pkg.sv =====
package mao_pkg;

	localparam int WindowDepth = 32;
	localparam int AddrW       = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
	localparam int PosW        = $clog2(WindowDepth + 1);
	localparam int SampleW     = 32;
	localparam int TapW        = 6;
	localparam int FactorW     = 16;
	localparam int CfgDataW    = 16;
	localparam int SumW        = SampleW + $clog2(WindowDepth);
	localparam int AluW        = SumW + 1;
	localparam int RemW        = FactorW + 1;
	localparam int CntMax      = (SumW > WindowDepth) ? SumW : WindowDepth;
	localparam int CntW        = $clog2(CntMax + 1);

	localparam logic [TapW-1:0]    TapCountReset = TapW'(32);
	localparam logic [FactorW-1:0] FactorReset   = FactorW'(1);

	typedef enum logic [2:0] {
		StIdle,
		StFill,
		StDivc,
		StSum,
		StAbs,
		StDiv,
		StNeg,
		StDone
	} state_t;

	typedef enum logic {
		CfgTapCount   = 1'b0,
		CfgOversample = 1'b1
	} cfg_reg_t;

endpackage

// ===== hdl/moving_average_oversampled.sv =====
// Channel   Direction  Handshake                        Payload
// sample    in         sample_valid / sample_stall      sample[31:0] signed
// result    out        result_valid / result_stall      filtered[31:0] signed, clipped
// cfg       in         cfg_valid / cfg_ready            cfg_index, cfg_data[15:0]
//
// Each sample runs 6 divisor steps, then the window reads, then 37 quotient steps,
// all through one shared add/subtract unit.
// The first sample after reset fills every entry of the window RAM.
// Reset sets tap_count to 32 and the oversampling factor to 1; the window needs no clear.
// A finished result waits in the output register; a new sample is taken meanwhile.
module moving_average_oversampled (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [mao_pkg::SampleW-1:0]  sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [mao_pkg::SampleW-1:0]  filtered,
	output logic                                clipped,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [mao_pkg::CfgDataW-1:0]        cfg_data
);

	mao_pkg::state_t state_q, state_d;

	logic [mao_pkg::TapW-1:0]              tap_count_q;
	logic [mao_pkg::FactorW-1:0]           factor_q;
	logic [mao_pkg::FactorW-1:0]           held_factor_q;
	logic                                  primed_q;
	logic [mao_pkg::PosW-1:0]              wpos_q;
	logic [mao_pkg::CntW-1:0]              cnt_q;
	logic [mao_pkg::TapW-1:0]              taps_q;
	logic [mao_pkg::TapW-1:0]              divisor_q;
	logic [mao_pkg::RemW-1:0]              rem_q;
	logic signed [mao_pkg::AluW-1:0]       acc_q;
	logic                                  neg_q;
	logic                                  rd_vld_q;
	logic                                  result_valid_q;
	logic signed [mao_pkg::SampleW-1:0]    filtered_q;
	logic                                  clipped_q;

	logic                                  accept;
	logic                                  out_free;
	logic [mao_pkg::TapW-1:0]              taps;
	logic [mao_pkg::PosW-1:0]              wpos_eff;
	logic                                  wr_en;
	logic [mao_pkg::AddrW-1:0]             wr_addr;
	logic [mao_pkg::SampleW-1:0]           rd_data;
	logic signed [mao_pkg::AluW-1:0]       alu_a;
	logic signed [mao_pkg::AluW-1:0]       alu_b;
	logic                                  alu_sub;
	logic signed [mao_pkg::AluW-1:0]       alu_y;
	logic                                  step_ok;
	logic [mao_pkg::RemW-1:0]              divc_shift;
	logic [mao_pkg::RemW-1:0]              div_shift;
	logic [mao_pkg::TapW-1:0]              div_next;
	logic                                  sum_more;
	logic [mao_pkg::AluW-mao_pkg::SampleW:0] upper;
	logic                                  in_range;
	logic signed [mao_pkg::SampleW-1:0]    sat_value;

	assign sample_stall = (state_q != mao_pkg::StIdle);
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign filtered     = filtered_q;
	assign clipped      = clipped_q;

	assign taps = (32'(tap_count_q) > mao_pkg::WindowDepth) ?
		mao_pkg::TapW'(mao_pkg::WindowDepth) : tap_count_q;
	assign wpos_eff = (32'(wpos_q) >= 32'(taps)) ? '0 : wpos_q;

	assign wr_en   = (accept && primed_q) || (state_q == mao_pkg::StFill);
	assign wr_addr = (state_q == mao_pkg::StFill) ?
		cnt_q[mao_pkg::AddrW-1:0] : wpos_eff[mao_pkg::AddrW-1:0];

	mao_window_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ((state_q == mao_pkg::StFill) ? acc_q[mao_pkg::SampleW-1:0] : sample),
		.rd_addr (cnt_q[mao_pkg::AddrW-1:0]),
		.rd_data (rd_data)
	);

	assign divc_shift = {rem_q[mao_pkg::RemW-2:0], divisor_q[mao_pkg::TapW-1]};
	assign div_shift  = {rem_q[mao_pkg::RemW-2:0], acc_q[mao_pkg::SumW-1]};
	assign sum_more   = (32'(cnt_q) < 32'(taps_q));

	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			mao_pkg::StSum: begin
				alu_a = acc_q;
				alu_b = mao_pkg::AluW'(signed'(rd_data));
			end
			mao_pkg::StDivc: begin
				alu_a   = mao_pkg::AluW'(divc_shift);
				alu_b   = mao_pkg::AluW'(held_factor_q);
				alu_sub = 1'b1;
			end
			mao_pkg::StDiv: begin
				alu_a   = mao_pkg::AluW'(div_shift);
				alu_b   = mao_pkg::AluW'(divisor_q);
				alu_sub = 1'b1;
			end
			mao_pkg::StAbs, mao_pkg::StNeg: begin
				alu_a   = '0;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = acc_q;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	mao_addsub u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	assign step_ok  = !alu_y[mao_pkg::AluW-1];
	assign div_next = {divisor_q[mao_pkg::TapW-2:0], step_ok};

	assign upper     = acc_q[mao_pkg::AluW-1:mao_pkg::SampleW-1];
	assign in_range  = (&upper) || !(|upper);
	assign sat_value = in_range ? acc_q[mao_pkg::SampleW-1:0] :
		(acc_q[mao_pkg::AluW-1] ? {1'b1, {(mao_pkg::SampleW-1){1'b0}}} :
		{1'b0, {(mao_pkg::SampleW-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mao_pkg::StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mao_pkg::StIdle: begin
				if (accept) begin
					state_d = primed_q ? mao_pkg::StDivc : mao_pkg::StFill;
				end
			end
			mao_pkg::StFill: begin
				if (32'(cnt_q) == mao_pkg::WindowDepth - 1) begin
					state_d = mao_pkg::StDone;
				end
			end
			mao_pkg::StDivc: begin
				if (32'(cnt_q) == mao_pkg::TapW - 1) begin
					state_d = mao_pkg::StSum;
				end
			end
			mao_pkg::StSum: begin
				if (!sum_more && !rd_vld_q) begin
					state_d = mao_pkg::StAbs;
				end
			end
			mao_pkg::StAbs: begin
				state_d = mao_pkg::StDiv;
			end
			mao_pkg::StDiv: begin
				if (32'(cnt_q) == mao_pkg::SumW - 1) begin
					state_d = mao_pkg::StNeg;
				end
			end
			mao_pkg::StNeg: begin
				state_d = mao_pkg::StDone;
			end
			mao_pkg::StDone: begin
				if (out_free) begin
					state_d = mao_pkg::StIdle;
				end
			end
			default: begin
				state_d = mao_pkg::StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q   <= mao_pkg::TapCountReset;
			factor_q      <= mao_pkg::FactorReset;
			held_factor_q <= mao_pkg::FactorReset;
			primed_q      <= 1'b0;
			wpos_q        <= '0;
			cnt_q         <= '0;
			rd_vld_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (mao_pkg::cfg_reg_t'(cfg_index))
					mao_pkg::CfgTapCount:   tap_count_q <= cfg_data[mao_pkg::TapW-1:0];
					mao_pkg::CfgOversample: factor_q    <= cfg_data[mao_pkg::FactorW-1:0];
				endcase
			end
			unique case (state_q)
				mao_pkg::StIdle: begin
					cnt_q    <= '0;
					rd_vld_q <= 1'b0;
					if (accept && !primed_q) begin
						held_factor_q <= (factor_q == '0) ? mao_pkg::FactorReset : factor_q;
					end
					if (accept && primed_q) begin
						wpos_q <= wpos_eff + mao_pkg::PosW'(1);
					end
				end
				mao_pkg::StFill: begin
					cnt_q <= cnt_q + mao_pkg::CntW'(1);
					if (32'(cnt_q) == mao_pkg::WindowDepth - 1) begin
						primed_q <= 1'b1;
					end
				end
				mao_pkg::StDivc: begin
					if (32'(cnt_q) == mao_pkg::TapW - 1) begin
						cnt_q    <= '0;
						rd_vld_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q + mao_pkg::CntW'(1);
					end
				end
				mao_pkg::StSum: begin
					rd_vld_q <= sum_more;
					if (sum_more) begin
						cnt_q <= cnt_q + mao_pkg::CntW'(1);
					end
				end
				mao_pkg::StAbs: begin
					cnt_q <= '0;
				end
				mao_pkg::StDiv: begin
					cnt_q <= cnt_q + mao_pkg::CntW'(1);
				end
				mao_pkg::StNeg, mao_pkg::StDone: begin
					cnt_q <= '0;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mao_pkg::StIdle: begin
				if (accept) begin
					acc_q     <= primed_q ? '0 : mao_pkg::AluW'(sample);
					taps_q    <= taps;
					divisor_q <= taps;
					rem_q     <= '0;
				end
			end
			mao_pkg::StDivc: begin
				rem_q <= step_ok ? alu_y[mao_pkg::RemW-1:0] : divc_shift;
				if (32'(cnt_q) == mao_pkg::TapW - 1 && div_next == '0) begin
					divisor_q <= mao_pkg::TapW'(1);
				end else begin
					divisor_q <= div_next;
				end
			end
			mao_pkg::StSum: begin
				if (rd_vld_q) begin
					acc_q <= alu_y;
				end
			end
			mao_pkg::StAbs: begin
				neg_q <= acc_q[mao_pkg::AluW-1];
				rem_q <= '0;
				if (acc_q[mao_pkg::AluW-1]) begin
					acc_q <= alu_y;
				end
			end
			mao_pkg::StDiv: begin
				rem_q <= step_ok ? alu_y[mao_pkg::RemW-1:0] : div_shift;
				acc_q <= {1'b0, acc_q[mao_pkg::SumW-2:0], step_ok};
			end
			mao_pkg::StNeg: begin
				if (neg_q) begin
					acc_q <= alu_y;
				end
			end
			mao_pkg::StFill, mao_pkg::StDone: begin
				acc_q <= acc_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == mao_pkg::StDone && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mao_pkg::StDone && out_free) begin
			filtered_q <= sat_value;
			clipped_q  <= !in_range;
		end
	end

endmodule

// ===== hdl/mao_addsub.sv =====
module mao_addsub (
	input  logic signed [mao_pkg::AluW-1:0] a,
	input  logic signed [mao_pkg::AluW-1:0] b,
	input  logic                            sub,
	output logic signed [mao_pkg::AluW-1:0] y
);

	always_comb begin
		if (sub) begin
			y = a - b;
		end else begin
			y = a + b;
		end
	end

endmodule

// ===== hdl/mao_window_ram.sv =====
module mao_window_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [mao_pkg::AddrW-1:0]   wr_addr,
	input  logic [mao_pkg::SampleW-1:0] wr_data,
	input  logic [mao_pkg::AddrW-1:0]   rd_addr,
	output logic [mao_pkg::SampleW-1:0] rd_data
);

	logic [mao_pkg::SampleW-1:0] mem [mao_pkg::WindowDepth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== tb/moving_average_oversampled_tb.sv =====
module moving_average_oversampled_tb;

	localparam int DrainCycles   = 120;
	localparam int HoldCycles    = 400;
	localparam int ItemsPerPhase = 610;
	localparam longint MaxQuot   = 64'sd2147483647;
	localparam longint MinQuot   = -64'sd2147483648;

	typedef struct packed {
		logic signed [mao_pkg::SampleW-1:0] filtered;
		logic                               clipped;
	} average_t;

	class average_tracker;
		logic signed [mao_pkg::SampleW-1:0] window [mao_pkg::WindowDepth];
		int unsigned                        write_pos;
		bit                                 primed;
		logic [mao_pkg::TapW-1:0]           tap_count;
		logic [mao_pkg::FactorW-1:0]        factor_reg;
		logic [mao_pkg::FactorW-1:0]        held_factor;
		average_t                           pending_averages [$];
		int                                 errors;

		function new();
			foreach (window[i])
				window[i] = '0;
			write_pos   = 0;
			primed      = 1'b0;
			tap_count   = mao_pkg::TapCountReset;
			factor_reg  = mao_pkg::FactorReset;
			held_factor = mao_pkg::FactorReset;
			errors      = 0;
		endfunction

		function void write_reg(mao_pkg::cfg_reg_t idx, logic [mao_pkg::CfgDataW-1:0] data);
			if (idx == mao_pkg::CfgTapCount) begin
				tap_count = data[mao_pkg::TapW-1:0];
			end else begin
				factor_reg = data[mao_pkg::FactorW-1:0];
			end
		endfunction

		function void note_sample(logic signed [mao_pkg::SampleW-1:0] s);
			int unsigned taps;
			int unsigned divisor;
			longint      sum;
			longint      quot;
			average_t    avg;
			if (!primed) begin
				foreach (window[i])
					window[i] = s;
				held_factor = factor_reg;
				primed = 1'b1;
				avg.filtered = s;
				avg.clipped = 1'b0;
				pending_averages.push_back(avg);
				return;
			end
			taps = tap_count;
			if (taps > mao_pkg::WindowDepth)
				taps = mao_pkg::WindowDepth;
			if (write_pos >= taps)
				write_pos = 0;
			if (write_pos < mao_pkg::WindowDepth)
				window[write_pos] = s;
			write_pos++;
			sum = 0;
			for (int i = 0; i < taps; i++)
				sum += longint'(window[i]);
			divisor = (held_factor != 0) ? taps / held_factor : taps;
			if (divisor == 0)
				divisor = 1;
			quot = sum / longint'(divisor);
			avg.clipped = 1'b0;
			if (quot > MaxQuot) begin
				quot = MaxQuot;
				avg.clipped = 1'b1;
			end else if (quot < MinQuot) begin
				quot = MinQuot;
				avg.clipped = 1'b1;
			end
			avg.filtered = quot[mao_pkg::SampleW-1:0];
			pending_averages.push_back(avg);
		endfunction

		function void check_result(logic signed [mao_pkg::SampleW-1:0] f, logic c);
			average_t exp_avg;
			if (pending_averages.size() == 0) begin
				$error("result with no request outstanding: filtered %0d clipped %0b", f, c);
				errors++;
				return;
			end
			exp_avg = pending_averages.pop_front();
			if (f !== exp_avg.filtered) begin
				$error("filtered: expected %0d, actual %0d", exp_avg.filtered, f);
				errors++;
			end
			if (c !== exp_avg.clipped) begin
				$error("clipped: expected %0b, actual %0b", exp_avg.clipped, c);
				errors++;
			end
		endfunction

		function int pending();
			return pending_averages.size();
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                sample_valid;
	logic                                sample_stall;
	logic signed [mao_pkg::SampleW-1:0]  sample;
	logic                                result_valid;
	logic                                result_stall;
	logic signed [mao_pkg::SampleW-1:0]  filtered;
	logic                                clipped;
	logic                                cfg_valid;
	logic                                cfg_ready;
	mao_pkg::cfg_reg_t                   cfg_index;
	logic [mao_pkg::CfgDataW-1:0]        cfg_data;

	average_tracker tracker;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left     = 0;
	bit hold_req      = 1'b0;

	moving_average_oversampled i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.filtered     (filtered),
		.clipped      (clipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HoldCycles;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				tracker.check_result(filtered, clipped);
			if (sample_valid && !sample_stall)
				tracker.note_sample(sample);
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_sample(logic signed [mao_pkg::SampleW-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		sample_valid <= 1'b0;
		while (tracker.pending() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic program_reg(mao_pkg::cfg_reg_t idx, logic [mao_pkg::CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [mao_pkg::SampleW-1:0] pick_sample(int bias);
		case (bias)
			1: return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
			2: return 32'h8000_0000 + $urandom_range(32'h3FFF_FFFF, 0);
			default: begin
				case ($urandom_range(9))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return $urandom_range(200) - 100;
					3: return 32'sh7FFF_FFFF - $urandom_range(1000);
					4: return 32'h8000_0000 + $urandom_range(1000);
					default: return $urandom();
				endcase
			end
		endcase
	endfunction

	task automatic run_phase(int send_pct, int recv_pct);
		int          sent;
		int          count;
		int          bias;
		logic [31:0] rnd;
		logic [5:0]  taps;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < ItemsPerPhase) begin
			wait_idle();
			rnd = $urandom();
			case ($urandom_range(7))
				0: taps = 6'd0;
				1: taps = 6'd1;
				2: taps = 6'($urandom_range(3, 2));
				3: taps = 6'd32;
				4: taps = 6'($urandom_range(63, 33));
				default: taps = 6'($urandom_range(32, 1));
			endcase
			program_reg(mao_pkg::CfgTapCount, {rnd[15:6], taps});
			if ($urandom_range(3) == 0)
				program_reg(mao_pkg::CfgOversample, rnd[31:16]);
			// stall the result side long enough to back up the input
			if (sent == 0)
				hold_req = 1'b1;
			count = $urandom_range(50, 30);
			bias = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
			repeat (count)
				send_sample(pick_sample(bias));
			sent += count;
		end
	endtask

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		result_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= mao_pkg::CfgTapCount;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_reg(mao_pkg::CfgOversample, 16'h0000);
		program_reg(mao_pkg::CfgOversample, 16'hFFFF);
		program_reg(mao_pkg::CfgOversample, 16'd3);
		program_reg(mao_pkg::CfgTapCount, 16'hFFE0);
		repeat (4) send_sample(32'sh7FFF_FFFF);
		repeat (2) send_sample(32'sh8000_0000);
		send_sample(32'sd0);
		send_sample(-32'sd1);
		wait_idle();

		program_reg(mao_pkg::CfgTapCount, 16'h0000);
		send_sample(32'sd5);
		send_sample(-32'sd7);
		wait_idle();

		program_reg(mao_pkg::CfgTapCount, 16'h0001);
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sd12345);
		wait_idle();

		program_reg(mao_pkg::CfgTapCount, 16'h003F);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		wait_idle();

		program_reg(mao_pkg::CfgTapCount, 16'h0003);
		repeat (3) send_sample(32'sh7FFF_FFFF);
		repeat (3) send_sample(32'sh8000_0000);
		wait_idle();

		program_reg(mao_pkg::CfgTapCount, 16'h0007);
		send_sample(-32'sd5);
		send_sample(32'sd3);

		run_phase(6, 75);
		run_phase(75, 6);
		run_phase(0, 0);
		wait_idle();

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== moving_average_oversampled.f =====
hdl/mao_pkg.sv
hdl/mao_addsub.sv
hdl/mao_window_ram.sv
hdl/moving_average_oversampled.sv
tb/moving_average_oversampled_tb.sv
